### sv/mcf_pkg.sv
package mcf_pkg;

   // Number of header bytes ahead of the data in each frame
   localparam int HEADER_BYTES = 4;

   // Sequence number wraps back to one when it reaches this value
   localparam logic [7:0] SEQ_WRAP = 8'd255;
   localparam logic [7:0] SEQ_RESTART = 8'd1;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESH_KEY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_KEY = 2'd1;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HSUM = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // Shared byte unit operations
   typedef enum logic [0:0] {
      ALU_ADD = 1'b0,
      ALU_XOR = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_req_type;

   // Pick key byte idx out of a 32-bit key word
   function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
      logic [31:0] shifted;
      shifted = key >> {idx, 3'b000};
      return shifted[7:0];
   endfunction

endpackage

### sv/mcf_ram.sv
module mcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### sv/mcf_alu.sv
module mcf_alu (
   input  mcf_pkg::alu_req_type req,
   output logic [7:0]           y
);

   // Shared 8-bit add / xor unit
   always_comb begin
      unique case (req.op)
         mcf_pkg::ALU_ADD: y = req.a + req.b;
         mcf_pkg::ALU_XOR: y = req.a ^ req.b;
         default:          y = req.a ^ req.b;
      endcase
   end

endmodule

### sv/mesh_command_framer_unit.sv
// Mesh command framer. Data bytes are offered with start while busy is low; a byte
// without last is taken and busy stays low. A byte with last is stored too and
// then the frame goes out: busy rises while the header check byte is folded
// and the 4 + N frame bytes are formed (N = stored data bytes, at most MAX_DATA),
// since every byte passes through one shared 8-bit add/xor unit and data comes from
// the store's single registered read port. Frame bytes appear on rsp_out_byte one per
// cycle with rsp_valid high for exactly one cycle each; the receiver cannot stall, so
// it must take every beat as it comes. Bytes past MAX_DATA are dropped.
module mesh_command_framer_unit #(
   parameter int MAX_DATA = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                start,
   output logic                                busy,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last,
   input  logic [15:0]                         req_target_id,
   input  logic [2:0]                          req_command_kind,
   input  logic                                req_forward,
   // frame bytes
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last_out,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mcf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);

   localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int CNT_W = $clog2(MAX_DATA + 1);
   localparam int N_W = $clog2(MAX_DATA + mcf_pkg::HEADER_BYTES);

   mcf_pkg::state_type state_ff, state_in;
   logic [N_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       seq_ff, seq_in;
   logic [7:0]       hdr0_ff, hdr0_in;
   logic [31:0]      mesh_key_ff, header_key_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;

   mcf_pkg::alu_req_type alu_req;
   logic [7:0]       alu_y;
   logic             accept;
   logic             room;
   logic             emit_last;
   logic [N_W-1:0]   rd_ptr;
   logic [7:0]       rdata;
   logic [7:0]       seq_next;

   assign accept = start && !busy;
   assign room = count_ff < CNT_W'(MAX_DATA);
   assign emit_last = n_ff == (N_W'(count_ff) + N_W'(mcf_pkg::HEADER_BYTES - 1));
   // data byte i is fetched while header or data beat i+3 is formed
   assign rd_ptr = n_ff - N_W'(mcf_pkg::HEADER_BYTES - 1);
   assign seq_next = seq_ff + 8'd1;

   mcf_alu u_alu (
      .req (alu_req),
      .y   (alu_y)
   );

   mcf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_DATA),
      .ADDR_W(IDX_W)
   ) u_store (
      .clock (clock),
      .we    (accept && room),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (req_data_byte),
      .raddr (rd_ptr[IDX_W-1:0]),
      .rdata (rdata)
   );

   // Sequencer and operand selection for the shared unit
   always_comb begin
      state_in = state_ff;
      n_in = n_ff;
      count_in = count_ff;
      sum_in = sum_ff;
      seq_in = seq_ff;
      hdr0_in = hdr0_ff;
      rsp_valid_in = 1'b0;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = 1'b0;
      alu_req.op = mcf_pkg::ALU_ADD;
      alu_req.a = sum_ff;
      alu_req.b = req_data_byte;
      unique case (state_ff)
         mcf_pkg::ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
                  sum_in = alu_y;
               end
               if (req_last) begin
                  hdr0_in = {req_forward, req_command_kind, req_target_id[11:8]};
                  n_in = '0;
                  state_in = mcf_pkg::ST_HSUM;
               end
            end
         end
         mcf_pkg::ST_HSUM: begin
            // fold header bytes 0..2 into the running data sum
            alu_req.op = mcf_pkg::ALU_ADD;
            alu_req.a = sum_ff;
            priority case (n_ff)
               N_W'(0): alu_req.b = hdr0_ff;
               N_W'(1): alu_req.b = seq_ff;
               default: alu_req.b = mcf_pkg::key_byte(mesh_key_ff, 2'd3);
            endcase
            sum_in = alu_y;
            if (n_ff == N_W'(2)) begin
               n_in = '0;
               state_in = mcf_pkg::ST_EMIT;
            end else begin
               n_in = n_ff + N_W'(1);
            end
         end
         mcf_pkg::ST_EMIT: begin
            // one frame byte per cycle, header key on header, mesh key on data
            alu_req.op = mcf_pkg::ALU_XOR;
            priority case (n_ff)
               N_W'(0): alu_req.a = hdr0_ff;
               N_W'(1): alu_req.a = seq_ff;
               N_W'(2): alu_req.a = mcf_pkg::key_byte(mesh_key_ff, 2'd3);
               N_W'(3): alu_req.a = sum_ff;
               default: alu_req.a = rdata;
            endcase
            if (n_ff < N_W'(mcf_pkg::HEADER_BYTES)) begin
               alu_req.b = mcf_pkg::key_byte(header_key_ff, n_ff[1:0]);
            end else begin
               alu_req.b = mcf_pkg::key_byte(mesh_key_ff, n_ff[1:0]);
            end
            rsp_valid_in = 1'b1;
            rsp_byte_in = alu_y;
            rsp_last_in = emit_last;
            n_in = n_ff + N_W'(1);
            if (emit_last) begin
               count_in = '0;
               sum_in = '0;
               seq_in = (seq_next >= mcf_pkg::SEQ_WRAP) ? mcf_pkg::SEQ_RESTART : seq_next;
               state_in = mcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcf_pkg::ST_IDLE;
         n_ff <= '0;
         count_ff <= '0;
         sum_ff <= '0;
         seq_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff <= 1'b0;
         mesh_key_ff <= '0;
         header_key_ff <= '0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         count_ff <= count_in;
         sum_ff <= sum_in;
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff <= rsp_last_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == mcf_pkg::CSR_MESH_KEY) begin
               mesh_key_ff <= csr_wdata;
            end
            if (csr_index == mcf_pkg::CSR_HEADER_KEY) begin
               header_key_ff <= csr_wdata;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hdr0_ff <= hdr0_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign busy = state_ff != mcf_pkg::ST_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_out = rsp_last_ff;

`ifndef NO_ASSERTIONS
   // a frame beat only follows an emit cycle
   a_beat_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == mcf_pkg::ST_EMIT))
      else $error("frame beat outside emit phase");

   // store count never passes its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DATA))
      else $error("byte count beyond store depth");

   // closing a frame clears the store and returns to idle
   a_frame_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcf_pkg::ST_EMIT && emit_last) |=>
         (count_ff == '0 && sum_ff == '0 && !busy && rsp_last_out))
      else $error("frame end did not clear state");

   // header folding always runs straight into emission
   a_hsum_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcf_pkg::ST_HSUM && n_ff == N_W'(2)) |=> state_ff == mcf_pkg::ST_EMIT)
      else $error("header sum did not lead to emission");
`endif

endmodule

### verif/mesh_command_framer_unit_tb.sv
`timescale 1ns / 1ps

module mesh_command_framer_unit_tb;

   localparam int FRAME_DATA_MAX = 16;
   // random part, sized so that the whole run offers about 330 command bytes
   localparam int RANDOM_ITEMS = 308;
   localparam int PHASE_ITEMS = 55;
   // outlasts the longest frame: check-byte folding, 4 header and MAX_DATA data bytes, with margin
   localparam int QUIET_CYCLES = 30;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int MAX_REPORTS = 10;
   localparam int TYPED_FRAME_BYTES = 5;

   // indexes the block has no register behind
   localparam logic [mcf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [mcf_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_3 = 2'd3;

   typedef enum logic [0:0] {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_op_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic [15:0] tid;
      logic [2:0]  cmd;
      logic        fwd;
   } cmd_beat_type;

   typedef struct packed {
      row_op_type                      op;
      cmd_beat_type                    beat;
      logic [mcf_pkg::CSR_INDEX_W-1:0] idx;
      logic [31:0]                     wdata;
      logic                            typed;
      logic [39:0]                     frame;   // typed frame, first byte in the top bits
   } stim_row_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } frame_byte_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [7:0] req_data_byte;
   logic req_last;
   logic [15:0] req_target_id;
   logic [2:0] req_command_kind;
   logic req_forward;
   logic rsp_valid;
   logic [7:0] rsp_out_byte;
   logic rsp_last_out;
   logic csr_valid;
   logic csr_ready;
   logic [mcf_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [31:0] csr_wdata;

   mesh_command_framer_unit #(.MAX_DATA(FRAME_DATA_MAX)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .req_target_id(req_target_id),
      .req_command_kind(req_command_kind),
      .req_forward(req_forward),
      .rsp_valid(rsp_valid),
      .rsp_out_byte(rsp_out_byte),
      .rsp_last_out(rsp_last_out),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // framer state mirror
   logic [7:0] cmd_store [FRAME_DATA_MAX];
   int stored_count = 0;
   logic [7:0] stored_sum = 8'd0;
   logic [7:0] seq_num = 8'd0;
   logic [31:0] mesh_key_r = 32'd0;
   logic [31:0] header_key_r = 32'd0;

   frame_byte_type frame_bytes_q [$];
   stim_row_type stim_table [$];

   int mismatch_count = 0;
   int leftover_bytes = 0;
   int bytes_checked = 0;
   int items_sent = 0;
   int frames_sent = 0;
   int dropped_bytes = 0;
   int csr_writes = 0;
   int idle_cycles = 0;
   bit no_gap_run = 1'b0;

   // Work out the frame a command byte causes and advance the mirror
   function automatic void frame_predict(input cmd_beat_type beat, input bit emit);
      logic [mcf_pkg::HEADER_BYTES-1:0][7:0] hdr;
      frame_byte_type fb;
      int total;
      if (stored_count < FRAME_DATA_MAX) begin
         cmd_store[stored_count] = beat.data;
         stored_count++;
         stored_sum = stored_sum + beat.data;
      end else begin
         dropped_bytes++;
      end
      if (!beat.last)
         return;
      hdr[0] = {beat.fwd, beat.cmd, beat.tid[11:8]};
      hdr[1] = seq_num;
      hdr[2] = mesh_key_r[31:24];
      hdr[3] = hdr[0] + hdr[1] + hdr[2] + stored_sum;
      total = mcf_pkg::HEADER_BYTES + stored_count;
      if (emit) begin
         for (int i = 0; i < mcf_pkg::HEADER_BYTES; i++) begin
            fb.value = hdr[i] ^ header_key_r[8*i +: 8];
            fb.last = (i + 1 == total);
            frame_bytes_q.push_back(fb);
         end
         for (int i = 0; i < stored_count; i++) begin
            fb.value = cmd_store[i] ^ mesh_key_r[8*(i % 4) +: 8];
            fb.last = (mcf_pkg::HEADER_BYTES + i + 1 == total);
            frame_bytes_q.push_back(fb);
         end
      end
      seq_num = (seq_num + 8'd1 >= mcf_pkg::SEQ_WRAP) ? mcf_pkg::SEQ_RESTART : seq_num + 8'd1;
      stored_count = 0;
      stored_sum = 8'd0;
      frames_sent++;
   endfunction

   function automatic void add_beat(input logic [7:0] d, input logic l, input logic [15:0] t,
                                    input logic [2:0] c, input logic f, input logic typed,
                                    input logic [39:0] frame);
      stim_row_type row;
      row = '0;
      row.op = ROW_ITEM;
      row.beat = '{data: d, last: l, tid: t, cmd: c, fwd: f};
      row.typed = typed;
      row.frame = frame;
      stim_table.push_back(row);
   endfunction

   function automatic void add_csr(input logic [mcf_pkg::CSR_INDEX_W-1:0] idx,
                                   input logic [31:0] data);
      stim_row_type row;
      row = '0;
      row.op = ROW_CSR;
      row.idx = idx;
      row.wdata = data;
      stim_table.push_back(row);
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s", $realtime, msg);
   endfunction

   // Offer one command beat after a random gap, hold it until taken
   task automatic send_item(input cmd_beat_type beat, input bit emit);
      int gap;
      if ($urandom_range(0, 15) == 0)
         no_gap_run = !no_gap_run;
      gap = no_gap_run ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_data_byte = beat.data;
      req_last = beat.last;
      req_target_id = beat.tid;
      req_command_kind = beat.cmd;
      req_forward = beat.fwd;
      start = 1'b1;
      do @(posedge clock); while (busy);
      frame_predict(beat, emit);
      items_sent++;
   endtask

   // Register write, only once the framer has drained
   task automatic write_csr(input logic [mcf_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      start = 1'b0;
      while (frame_bytes_q.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mcf_pkg::CSR_MESH_KEY:   mesh_key_r = data;
         mcf_pkg::CSR_HEADER_KEY: header_key_r = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Frame byte checker
   always @(posedge clock) begin : frame_check
      frame_byte_type exp_b;
      if (!reset && rsp_valid) begin
         bytes_checked++;
         if (frame_bytes_q.size() == 0) begin
            note_mismatch($sformatf("unexpected frame byte %02h last %0b",
                                    rsp_out_byte, rsp_last_out));
         end else begin
            exp_b = frame_bytes_q.pop_front();
            if (rsp_out_byte !== exp_b.value || rsp_last_out !== exp_b.last)
               note_mismatch($sformatf("frame byte expected %02h last %0b, got %02h last %0b",
                                       exp_b.value, exp_b.last, rsp_out_byte, rsp_last_out));
         end
      end
   end

   // Watchdog: any beat on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      cmd_beat_type beat;
      frame_byte_type fb;
      int len;
      int r;
      int phase;
      int phase_items;
      int random_items;

      reset = 1'b1;
      start = 1'b0;
      req_data_byte = 8'd0;
      req_last = 1'b0;
      req_target_id = 16'd0;
      req_command_kind = 3'd0;
      req_forward = 1'b0;
      csr_valid = 1'b0;
      csr_index = mcf_pkg::CSR_MESH_KEY;
      csr_wdata = 32'd0;

      // Directed rows: all-zero and all-ones frames from reset keys
      add_beat(8'h00, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b1, 40'h00_00_00_00_00);
      add_beat(8'hFF, 1'b1, 16'hFFFF, 3'd7, 1'b1, 1'b1, 40'hFF_01_00_FF_FF);
      // overfull store: the last two bytes must be dropped
      for (int i = 0; i < FRAME_DATA_MAX + 2; i++)
         add_beat(8'(i * 15 + 1), i == FRAME_DATA_MAX + 1, 16'h0A5A, 3'd5, 1'b0, 1'b0, '0);
      // all-ones keys; writes to unused indexes must leave them alone
      add_csr(mcf_pkg::CSR_MESH_KEY, 32'hFFFF_FFFF);
      add_csr(mcf_pkg::CSR_HEADER_KEY, 32'hFFFF_FFFF);
      add_csr(CSR_UNUSED_2, 32'h0000_0000);
      add_csr(CSR_UNUSED_3, 32'h1234_5678);
      add_beat(8'h00, 1'b1, 16'h0000, 3'd0, 1'b0, 1'b1, 40'hFF_FC_00_FD_FF);
      add_beat(8'h5A, 1'b1, 16'hF0FF, 3'd2, 1'b0, 1'b0, '0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (stim_table[n]) begin
         row = stim_table[n];
         if (row.op == ROW_CSR) begin
            write_csr(row.idx, row.wdata);
         end else begin
            send_item(row.beat, !row.typed);
            if (row.typed) begin
               for (int k = 0; k < TYPED_FRAME_BYTES; k++) begin
                  fb.value = row.frame[39 - 8*k -: 8];
                  fb.last = (k == TYPED_FRAME_BYTES - 1);
                  frame_bytes_q.push_back(fb);
               end
            end
         end
      end

      // Random frames, key setting changes per phase
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase % 6)
            0: begin
               write_csr(mcf_pkg::CSR_MESH_KEY, 32'h0000_0000);
               write_csr(mcf_pkg::CSR_HEADER_KEY, 32'h0000_0000);
            end
            1: begin
               write_csr(mcf_pkg::CSR_MESH_KEY, $urandom());
               write_csr(mcf_pkg::CSR_HEADER_KEY, $urandom());
            end
            2: begin
               write_csr(mcf_pkg::CSR_MESH_KEY, 32'hFFFF_FFFF);
               write_csr(mcf_pkg::CSR_HEADER_KEY, $urandom());
            end
            3: begin
               write_csr(mcf_pkg::CSR_HEADER_KEY, 32'hFFFF_FFFF);
               write_csr(mcf_pkg::CSR_MESH_KEY, $urandom());
            end
            4: begin
               write_csr(mcf_pkg::CSR_MESH_KEY, 32'hFFFF_FFFF);
               write_csr(mcf_pkg::CSR_HEADER_KEY, 32'hFFFF_FFFF);
            end
            default: begin
               write_csr(mcf_pkg::CSR_MESH_KEY, $urandom());
               write_csr(mcf_pkg::CSR_HEADER_KEY, 32'h0000_0000);
            end
         endcase
         if ($urandom_range(0, 1))
            write_csr($urandom_range(0, 1) ? CSR_UNUSED_2 : CSR_UNUSED_3, $urandom());

         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            // mostly short frames, some long, a few that overflow the store
            r = $urandom_range(0, 99);
            if (r < 65)
               len = 1;
            else if (r < 87)
               len = $urandom_range(2, 5);
            else if (r < 96)
               len = $urandom_range(6, FRAME_DATA_MAX);
            else
               len = $urandom_range(FRAME_DATA_MAX + 1, FRAME_DATA_MAX + 6);
            for (int k = 0; k < len; k++) begin
               beat.data = 8'($urandom_range(0, 255));
               beat.last = (k == len - 1);
               beat.tid = 16'($urandom_range(0, 65535));
               beat.cmd = 3'($urandom_range(0, 7));
               beat.fwd = 1'($urandom_range(0, 1));
               send_item(beat, 1'b1);
            end
            phase_items += len;
            random_items += len;
         end
         phase++;
      end

      // Drain, then let the framer settle
      @(negedge clock);
      start = 1'b0;
      while (frame_bytes_q.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      leftover_bytes = frame_bytes_q.size();
      if (leftover_bytes != 0)
         $display("%0d expected frame bytes never arrived", leftover_bytes);

      $display("Sent %0d command bytes in %0d frames (%0d bytes dropped on full store), %0d key writes",
               items_sent, frames_sent, dropped_bytes, csr_writes);
      $display("Checked %0d frame bytes, %0d mismatches", bytes_checked, mismatch_count);
      if (mismatch_count == 0 && leftover_bytes == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
sv/mcf_pkg.sv
sv/mcf_ram.sv
sv/mcf_alu.sv
sv/mesh_command_framer_unit.sv
verif/mesh_command_framer_unit_tb.sv
